FILE: hw/rtl/tabu_pkg.sv
// ----------------------------------------------------------------------------
// tabu_pkg
// shared types, widths and codes for the tabu list with aspiration
// ----------------------------------------------------------------------------
package tabu_pkg;

	// defaults for the top level parameters
	localparam int unsigned MAX_POSITIONS_DEF = 16;
	localparam int unsigned TABU_DEPTH_DEF    = 64;

	// fixed field widths
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned COST_W  = 30;
	localparam int unsigned EPS_W   = 16;
	localparam int unsigned SIZE_W  = 7;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// aspiration arithmetic: costs scaled to Q.8, product of eps and step difference
	localparam int unsigned FRAC_W    = 8;
	localparam int unsigned DIFF_W    = STEP_W + 1;
	localparam int unsigned ACC_W     = COST_W + FRAC_W + 2;
	localparam int unsigned MUL_STEPS = EPS_W;
	localparam int unsigned BIT_W     = $clog2(MUL_STEPS);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ASP_EPS  = 1'd1;

	// register reset values
	localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 7'd64;
	localparam logic [EPS_W-1:0]  ASP_EPS_RST  = 16'd0;

	// action codes
	localparam logic ACT_QUERY  = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	// input beat
	typedef struct packed {
		logic              action;
		logic [IDX_W-1:0]  first_index;
		logic [IDX_W-1:0]  second_index;
		logic [STEP_W-1:0] step_number;
		logic [COST_W-1:0] neighbor_cost;
		logic [COST_W-1:0] best_cost;
	} in_item_t;

	// output beat
	typedef struct packed {
		logic tabu_hit;
		logic aspired;
		logic admissible;
		logic evicted;
	} out_item_t;

	// sequencer to aspiration unit
	typedef struct packed {
		logic start;
	} asp_ctrl_t;

	// aspiration unit back to sequencer
	typedef struct packed {
		logic busy;
		logic done;
		logic aspired;
	} asp_stat_t;

endpackage

FILE: hw/rtl/tabu_asp_unit.sv
// ----------------------------------------------------------------------------
// tabu_asp_unit
// aspiration test: sign of (ncost - bcost)*256 + eps*(step - last), formed by
// one shared adder as a shift-add multiply, one eps bit per cycle
// ----------------------------------------------------------------------------
module tabu_asp_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tabu_pkg::asp_ctrl_t                 ctrl,
	input  logic signed [tabu_pkg::EPS_W-1:0]   eps,
	input  logic        [tabu_pkg::STEP_W-1:0]  step,
	input  logic        [tabu_pkg::STEP_W-1:0]  last,
	input  logic        [tabu_pkg::COST_W-1:0]  ncost,
	input  logic        [tabu_pkg::COST_W-1:0]  bcost,
	output tabu_pkg::asp_stat_t                 stat
);

	localparam int unsigned AW = tabu_pkg::ACC_W;

	logic signed [AW-1:0]                 acc_q;
	logic signed [AW-1:0]                 mcand_q;
	logic        [tabu_pkg::EPS_W-1:0]    mplier_q;
	logic        [tabu_pkg::BIT_W-1:0]    bit_q;
	logic                                 busy_q;
	logic                                 done_q;

	logic signed [tabu_pkg::DIFF_W-1:0]   diff;
	logic        [AW-1:0]                 op_a;
	logic        [AW-1:0]                 op_b;
	logic                                 op_sub;
	logic        [AW-1:0]                 sum;
	logic                                 last_bit;

	// signed step difference, exact
	assign diff = signed'({1'b0, step}) - signed'({1'b0, last});

	assign last_bit = (bit_q == tabu_pkg::BIT_W'(tabu_pkg::MUL_STEPS - 1));

	// operand select for the shared adder
	always_comb begin
		if (ctrl.start) begin
			op_a   = AW'({ncost, tabu_pkg::FRAC_W'(0)});
			op_b   = AW'({bcost, tabu_pkg::FRAC_W'(0)});
			op_sub = 1'b1;
		end else begin
			op_a   = acc_q;
			op_b   = mcand_q;
			// top eps bit carries negative weight
			op_sub = last_bit;
		end
	end

	// shared adder / subtractor
	assign sum = op_a + (op_sub ? ~op_b : op_b) + AW'(op_sub);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (busy_q) begin
			bit_q <= bit_q + 1'b1;
			if (last_bit) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q    <= sum;
			mcand_q  <= AW'(diff);
			mplier_q <= eps;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= sum;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign stat.busy    = busy_q;
	assign stat.done    = done_q;
	assign stat.aspired = acc_q[AW-1];

endmodule

FILE: hw/rtl/tabu_list_with_aspiration.sv
// ----------------------------------------------------------------------------
// tabu_list_with_aspiration
// tabu memory for swap moves with fifo ageing and an aspiration test
// ----------------------------------------------------------------------------
// One item at a time. After reset the flag and last-step tables are cleared
// one entry per cycle, during which in_ready stays low; configuration writes
// are taken throughout. A query passes through the table lookup, the
// aspiration unit (16 shift-add steps, one bit of eps per cycle, then done
// reported) and the load of the output register. An insert passes through
// the lookup and the output load, with a further state between them when the
// oldest entry is evicted from a non-empty fifo (its flag clear is a second
// write to the flag table). The next item is accepted once the result sits in
// the output register, even if it has not yet been taken; a result still
// waiting there holds the next one back.
module tabu_list_with_aspiration #(
	parameter int unsigned MAX_POSITIONS = tabu_pkg::MAX_POSITIONS_DEF,
	parameter int unsigned TABU_DEPTH    = tabu_pkg::TABU_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tabu_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tabu_pkg::out_item_t               out_item,
	input  logic                              cfg_write,
	input  logic [tabu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tabu_pkg::CFG_W-1:0]        cfg_data
);

	localparam int unsigned NUM_KEYS = MAX_POSITIONS * MAX_POSITIONS;
	localparam int unsigned KEY_W    = $clog2(NUM_KEYS);
	localparam int unsigned POS_W    = $clog2(MAX_POSITIONS);
	localparam int unsigned PTR_W    = (TABU_DEPTH > 1) ? $clog2(TABU_DEPTH) : 1;
	localparam int unsigned CNT_W    = $clog2(TABU_DEPTH + 1);
	localparam int unsigned CMP_W    = (CNT_W > tabu_pkg::SIZE_W) ? CNT_W : tabu_pkg::SIZE_W;
	localparam int unsigned SUM_W    = CNT_W + 1;
	localparam int unsigned WRAP_W   = tabu_pkg::SIZE_W;

	// sequencer states
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOOKUP = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_EVICT  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]                          state_q;
	logic [KEY_W-1:0]                    clr_q;

	logic [tabu_pkg::SIZE_W-1:0]         max_size_q;
	logic [tabu_pkg::EPS_W-1:0]          eps_q;

	tabu_pkg::in_item_t                  item_q;
	logic [KEY_W-1:0]                    key_q;
	logic [PTR_W-1:0]                    head_q;
	logic [CNT_W-1:0]                    count_q;
	logic                                evict_q;

	logic                                flag_mem [NUM_KEYS];
	logic [tabu_pkg::STEP_W-1:0]         step_mem [NUM_KEYS];
	logic [KEY_W-1:0]                    fifo_mem [TABU_DEPTH];

	logic                                flag_rd_q;
	logic [tabu_pkg::STEP_W-1:0]         step_rd_q;
	logic [KEY_W-1:0]                    fifo_rd_q;

	tabu_pkg::out_item_t                 out_item_q;
	logic                                out_valid_q;

	logic [POS_W-1:0]                    pos_i;
	logic [POS_W-1:0]                    pos_j;
	logic [KEY_W-1:0]                    key_in;
	logic                                in_fire;
	logic                                rd_en;
	logic [CMP_W-1:0]                    cap;
	logic                                full;
	logic                                count_zero;
	logic [SUM_W-1:0]                    tail_sum;
	logic [PTR_W-1:0]                    tail;
	logic                                do_insert;
	logic                                flag_we;
	logic [KEY_W-1:0]                    flag_wa;
	logic                                flag_wd;
	logic                                step_we;
	logic [KEY_W-1:0]                    step_wa;
	logic [tabu_pkg::STEP_W-1:0]         step_wd;
	logic                                out_load;
	tabu_pkg::asp_ctrl_t                 asp_ctrl;
	tabu_pkg::asp_stat_t                 asp_stat;

	// position wrap modulo MAX_POSITIONS by repeated subtraction
	function automatic logic [POS_W-1:0] pos_wrap(input logic [tabu_pkg::IDX_W-1:0] idx);
		logic [WRAP_W-1:0] v;
		v = WRAP_W'(idx);
		for (int k = 0; k < 8; k++) begin
			if (v >= WRAP_W'(MAX_POSITIONS)) begin
				v = v - WRAP_W'(MAX_POSITIONS);
			end
		end
		return POS_W'(v);
	endfunction

	// move key of the incoming beat
	always_comb begin
		pos_i  = pos_wrap(in_item.first_index);
		pos_j  = pos_wrap(in_item.second_index);
		key_in = KEY_W'(int'(pos_i) * MAX_POSITIONS + int'(pos_j));
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign rd_en    = (state_q == ST_IDLE);

	// fifo occupancy against the effective capacity
	always_comb begin
		if (32'(max_size_q) > TABU_DEPTH) begin
			cap = CMP_W'(TABU_DEPTH);
		end else begin
			cap = CMP_W'(max_size_q);
		end
		full       = (CMP_W'(count_q) >= cap);
		count_zero = (count_q == '0);
		tail_sum   = SUM_W'(head_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(TABU_DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(TABU_DEPTH);
		end
		tail = PTR_W'(tail_sum);
	end

	assign do_insert = (state_q == ST_LOOKUP) && (item_q.action == tabu_pkg::ACT_INSERT);

	// write port select for the flag and last-step tables
	always_comb begin
		flag_we = 1'b0;
		flag_wa = key_q;
		flag_wd = 1'b0;
		step_we = 1'b0;
		step_wa = key_q;
		step_wd = item_q.step_number;
		if (state_q == ST_CLEAR) begin
			flag_we = 1'b1;
			flag_wa = clr_q;
			step_we = 1'b1;
			step_wa = clr_q;
			step_wd = '0;
		end else if (do_insert) begin
			flag_we = 1'b1;
			// zero capacity pushes and pops the same move at once
			flag_wd = !(full && count_zero);
			step_we = 1'b1;
		end else if (state_q == ST_EVICT) begin
			flag_we = 1'b1;
			flag_wa = fifo_rd_q;
		end
	end

	// flag table
	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		if (rd_en) begin
			flag_rd_q <= flag_mem[key_in];
		end
	end

	// last-step table
	always_ff @(posedge clk) begin
		if (step_we) begin
			step_mem[step_wa] <= step_wd;
		end
		if (rd_en) begin
			step_rd_q <= step_mem[key_in];
		end
	end

	// move fifo, head read while idle, ahead of any push by the insert
	always_ff @(posedge clk) begin
		if (do_insert && !(full && count_zero)) begin
			fifo_mem[tail] <= key_q;
		end
		if (rd_en) begin
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= tabu_pkg::MAX_SIZE_RST;
			eps_q      <= tabu_pkg::ASP_EPS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tabu_pkg::CFG_MAX_SIZE: max_size_q <= cfg_data[tabu_pkg::SIZE_W-1:0];
				tabu_pkg::CFG_ASP_EPS:  eps_q      <= cfg_data[tabu_pkg::EPS_W-1:0];
			endcase
		end
	end

	// captured beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_item;
			key_q  <= key_in;
		end
	end

	assign asp_ctrl.start = (state_q == ST_LOOKUP) && (item_q.action == tabu_pkg::ACT_QUERY);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// sequencer and fifo pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			count_q <= '0;
			evict_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == KEY_W'(NUM_KEYS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					evict_q <= 1'b0;
					if (item_q.action == tabu_pkg::ACT_QUERY) begin
						state_q <= ST_MUL;
					end else if (!full) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_DONE;
					end else begin
						evict_q <= 1'b1;
						if (count_zero) begin
							state_q <= ST_DONE;
						end else begin
							if (head_q == PTR_W'(TABU_DEPTH - 1)) begin
								head_q <= '0;
							end else begin
								head_q <= head_q + 1'b1;
							end
							state_q <= ST_EVICT;
						end
					end
				end
				ST_MUL: begin
					if (asp_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_EVICT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (item_q.action == tabu_pkg::ACT_QUERY) begin
				out_item_q.tabu_hit   <= flag_rd_q;
				out_item_q.aspired    <= asp_stat.aspired;
				out_item_q.admissible <= !flag_rd_q || asp_stat.aspired;
				out_item_q.evicted    <= 1'b0;
			end else begin
				out_item_q.tabu_hit   <= 1'b0;
				out_item_q.aspired    <= 1'b0;
				out_item_q.admissible <= 1'b0;
				out_item_q.evicted    <= evict_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// aspiration unit
	tabu_asp_unit u_asp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (asp_ctrl),
		.eps    (signed'(eps_q)),
		.step   (item_q.step_number),
		.last   (step_rd_q),
		.ncost  (item_q.neighbor_cost),
		.bcost  (item_q.best_cost),
		.stat   (asp_stat)
	);

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the tabu list with aspiration against a cycle-free mirror of its
// flag table, fifo and last-step table; directed moves first, then phases of
// tabu-search-like traffic under several register settings, with random
// gaps on both channels and one long hold-off of the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int unsigned POSITIONS = tabu_pkg::MAX_POSITIONS_DEF;
	localparam int unsigned DEPTH     = tabu_pkg::TABU_DEPTH_DEF;
	localparam int unsigned KEYS      = POSITIONS * POSITIONS;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned IDX_W     = tabu_pkg::IDX_W;
	localparam int unsigned STEP_W    = tabu_pkg::STEP_W;
	localparam int unsigned COST_W    = tabu_pkg::COST_W;
	localparam int unsigned CFG_W     = tabu_pkg::CFG_W;
	localparam int unsigned ITEM_W    = $bits(tabu_pkg::in_item_t);
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	// mirror of the tabu memory, holding the flags each beat should produce
	class tabu_mirror;
		bit                          marks[KEYS];
		logic [7:0]                  slots[DEPTH];
		logic [15:0]                 last_use[KEYS];
		int unsigned                 head;
		int unsigned                 count;
		logic [tabu_pkg::SIZE_W-1:0] size_reg;
		logic signed [tabu_pkg::EPS_W-1:0] eps_reg;
		tabu_pkg::out_item_t         flags_due[$];
		int unsigned                 errors;
		int unsigned                 queries;
		int unsigned                 inserts;
		int unsigned                 evictions;
		int unsigned                 aspired_seen;
		int unsigned                 settings;

		function new();
			for (int k = 0; k < KEYS; k++) begin
				marks[k] = 1'b0;
				last_use[k] = '0;
			end
			head = 0;
			count = 0;
			size_reg = tabu_pkg::MAX_SIZE_RST;
			eps_reg = tabu_pkg::ASP_EPS_RST;
			errors = 0;
			queries = 0;
			inserts = 0;
			evictions = 0;
			aspired_seen = 0;
			settings = 1;
		endfunction

		function void set_register(logic [tabu_pkg::CFG_IDX_W-1:0] idx,
				logic [tabu_pkg::CFG_W-1:0] data);
			if (idx == tabu_pkg::CFG_MAX_SIZE)
				size_reg = data[tabu_pkg::SIZE_W-1:0];
			else if (idx == tabu_pkg::CFG_ASP_EPS)
				eps_reg = data[tabu_pkg::EPS_W-1:0];
			settings++;
		endfunction

		// work out the flags of one accepted move beat and update the mirror
		function void absorb_move(tabu_pkg::in_item_t mv);
			tabu_pkg::out_item_t r;
			int unsigned key;
			int unsigned oldest;
			int unsigned cap;
			longint      diff;
			longint      lhs;
			longint      rhs;
			r = '0;
			key = (mv.first_index % POSITIONS) * POSITIONS + (mv.second_index % POSITIONS);
			cap = (size_reg > DEPTH) ? DEPTH : size_reg;
			if (mv.action == tabu_pkg::ACT_QUERY) begin
				diff = longint'(mv.step_number) - longint'(last_use[key]);
				lhs = longint'(mv.neighbor_cost) * 256 + longint'(eps_reg) * diff;
				rhs = longint'(mv.best_cost) * 256;
				r.tabu_hit = marks[key];
				r.aspired = (lhs < rhs);
				r.admissible = !r.tabu_hit || r.aspired;
				queries++;
				if (r.aspired)
					aspired_seen++;
			end else begin
				marks[key] = 1'b1;
				last_use[key] = mv.step_number;
				inserts++;
				if (count >= cap) begin
					// full: push behind the oldest and pop it, or drop at once when empty
					if (count == 0) begin
						oldest = key;
					end else begin
						oldest = slots[head] % KEYS;
						slots[(head + count) % DEPTH] = 8'(key);
						head = (head + 1) % DEPTH;
					end
					marks[oldest] = 1'b0;
					r.evicted = 1'b1;
					evictions++;
				end else begin
					slots[(head + count) % DEPTH] = 8'(key);
					count++;
				end
			end
			flags_due = {flags_due, r};
		endfunction

		function void report(string name, logic want, logic got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted result beat with the oldest expected flags
		function void match_flags(tabu_pkg::out_item_t got);
			tabu_pkg::out_item_t want;
			if (flags_due.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %b", $time, got);
				errors++;
			end else begin
				want = flags_due.pop_front();
				report("tabu_hit", want.tabu_hit, got.tabu_hit);
				report("aspired", want.aspired, got.aspired);
				report("admissible", want.admissible, got.admissible);
				report("evicted", want.evicted, got.evicted);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	tabu_pkg::in_item_t             in_item = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	tabu_pkg::out_item_t            out_item;
	logic                           cfg_write = 1'b0;
	logic [tabu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tabu_pkg::CFG_W-1:0]     cfg_data = '0;

	bit          calm = 1'b0;
	int unsigned hold_ticket = 0;
	int unsigned quiet_cycles = 0;
	logic [15:0] search_step = '0;
	tabu_mirror  mirror;

	tabu_list_with_aspiration uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function tabu_pkg::in_item_t move(logic act, int unsigned a, int unsigned b, int unsigned s,
			logic [COST_W-1:0] nc, logic [COST_W-1:0] bc);
		tabu_pkg::in_item_t m;
		m.action = act;
		m.first_index = IDX_W'(a);
		m.second_index = IDX_W'(b);
		m.step_number = STEP_W'(s);
		m.neighbor_cost = nc;
		m.best_cost = bc;
		return m;
	endfunction

	// offer one move beat, sometimes after a random gap, and return at its accept edge
	task automatic offer(tabu_pkg::in_item_t mv);
		if (!calm && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 22)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= mv;
		do @(posedge clk); while (!in_ready);
		mirror.absorb_move(mv);
	endtask

	// register write once every expected result is back
	task automatic write_register(logic [tabu_pkg::CFG_IDX_W-1:0] idx,
			logic [tabu_pkg::CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (mirror.flags_due.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		mirror.set_register(idx, data);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function int unsigned pick_index();
		if ($urandom_range(99) < 70)
			return $urandom_range(0, 4);
		return $urandom_range(0, POSITIONS - 1);
	endfunction

	// search-like traffic: a few queries then one insert per step, with noise
	task automatic run_phase(int unsigned beats, bit with_hold);
		int unsigned sent;
		int unsigned burst;
		logic [COST_W-1:0] bc;
		longint nc;
		logic [95:0] raw;
		tabu_pkg::in_item_t mv;
		sent = 0;
		while (sent < beats) begin
			if (with_hold && sent >= beats / 2 && sent < beats / 2 + 5) begin
				hold_ticket <= hold_ticket + 1;
				with_hold = 1'b0;
			end
			if ($urandom_range(99) < 5)
				search_step = STEP_W'($urandom());
			else
				search_step = STEP_W'(search_step + $urandom_range(0, 3));
			burst = $urandom_range(0, 4);
			for (int q = 0; q <= burst; q++) begin
				case ($urandom_range(9))
					0: bc = '0;
					1: bc = COST_MAX;
					default: bc = COST_W'($urandom()) & COST_MAX;
				endcase
				nc = longint'(bc) + longint'($urandom_range(0, 4000)) - 2000;
				if (nc < 0)
					nc = 0;
				if (nc > longint'(COST_MAX))
					nc = longint'(COST_MAX);
				mv = move((q == burst) ? tabu_pkg::ACT_INSERT : tabu_pkg::ACT_QUERY,
					pick_index(), pick_index(), search_step, COST_W'(nc), bc);
				if ($urandom_range(99) < 10) begin
					raw = {$urandom(), $urandom(), $urandom()};
					mv = raw[ITEM_W-1:0];
				end
				offer(mv);
				sent++;
			end
		end
	endtask

	// result side: check every beat, idle at random, hold off when asked
	initial begin
		int unsigned hold_left;
		int unsigned seen_ticket;
		hold_left = 0;
		seen_ticket = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				mirror.match_flags(out_item);
			if (hold_ticket != seen_ticket) begin
				seen_ticket = hold_ticket;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 24);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus
	initial begin
		mirror = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: untouched moves, cost extremes and one insert queried both ways round
		offer(move(tabu_pkg::ACT_QUERY, 0, 0, 0, 0, 0));
		offer(move(tabu_pkg::ACT_QUERY, 15, 15, 16'hFFFF, 0, COST_MAX));
		offer(move(tabu_pkg::ACT_QUERY, 15, 0, 0, COST_MAX, COST_MAX));
		offer(move(tabu_pkg::ACT_INSERT, 3, 5, 10, 0, 0));
		offer(move(tabu_pkg::ACT_QUERY, 3, 5, 11, 5, 4));
		offer(move(tabu_pkg::ACT_QUERY, 5, 3, 11, 5, 4));
		offer(move(tabu_pkg::ACT_QUERY, 3, 5, 12, 4, 5));

		// zero capacity, most negative eps, step before and after last use
		write_register(tabu_pkg::CFG_ASP_EPS, 16'h8000);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd0);
		offer(move(tabu_pkg::ACT_INSERT, 1, 2, 100, 0, 0));
		offer(move(tabu_pkg::ACT_QUERY, 1, 2, 50, 0, 0));
		offer(move(tabu_pkg::ACT_QUERY, 1, 2, 200, 100, 100));

		// eviction clears a mark while its duplicate is still queued
		write_register(tabu_pkg::CFG_ASP_EPS, 16'h7FFF);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd2);
		offer(move(tabu_pkg::ACT_INSERT, 7, 7, 300, 0, 0));
		offer(move(tabu_pkg::ACT_INSERT, 7, 7, 301, 0, 0));
		offer(move(tabu_pkg::ACT_INSERT, 8, 9, 302, 0, 0));
		offer(move(tabu_pkg::ACT_QUERY, 7, 7, 303, 10, 10));
		offer(move(tabu_pkg::ACT_INSERT, 8, 9, 304, 0, 0));
		offer(move(tabu_pkg::ACT_QUERY, 8, 9, 305, 10, 10));

		// capacity lowered below the count, then step far before last use
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd1);
		offer(move(tabu_pkg::ACT_INSERT, 2, 2, 400, 0, 0));
		offer(move(tabu_pkg::ACT_QUERY, 8, 9, 401, COST_MAX, 0));
		offer(move(tabu_pkg::ACT_QUERY, 2, 2, 0, 0, 1));
		offer(move(tabu_pkg::ACT_INSERT, 15, 15, 16'hFFFF, COST_MAX, COST_MAX));
		offer(move(tabu_pkg::ACT_QUERY, 15, 15, 0, COST_MAX, COST_MAX));

		// random phases over several register settings
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd64);
		write_register(tabu_pkg::CFG_ASP_EPS, 16'h0000);
		run_phase(245, 1'b0);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd0);
		write_register(tabu_pkg::CFG_ASP_EPS, CFG_W'($urandom()));
		calm <= 1'b1;
		run_phase(245, 1'b0);
		calm <= 1'b0;
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd1);
		write_register(tabu_pkg::CFG_ASP_EPS, 16'h8000);
		run_phase(245, 1'b0);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd3);
		write_register(tabu_pkg::CFG_ASP_EPS, 16'h7FFF);
		run_phase(245, 1'b1);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd16);
		write_register(tabu_pkg::CFG_ASP_EPS, 16'hFFFF);
		run_phase(245, 1'b0);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd127);
		write_register(tabu_pkg::CFG_ASP_EPS, CFG_W'($urandom()));
		run_phase(245, 1'b0);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd65);
		write_register(tabu_pkg::CFG_ASP_EPS, 16'h0001);
		run_phase(245, 1'b0);
		write_register(tabu_pkg::CFG_MAX_SIZE, 16'd5);
		write_register(tabu_pkg::CFG_ASP_EPS, CFG_W'($urandom()));
		run_phase(245, 1'b0);

		// drain and let the block settle
		in_valid <= 1'b0;
		while (mirror.flags_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d queries (%0d aspired) and %0d inserts (%0d evicting)",
			mirror.queries, mirror.aspired_seen, mirror.inserts, mirror.evictions);
		$display("over %0d register settings, with one long result hold-off; %0d mismatches",
			mirror.settings, mirror.errors);
		if (mirror.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
